FILE: rtl/shell_sort_halving_gaps_macros.svh
// ----------------------------------------------------------------------------
// shell_sort_halving_gaps_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SHELL_SORT_HALVING_GAPS_MACROS_SVH
`define SHELL_SORT_HALVING_GAPS_MACROS_SVH

// labeled concurrent assertion on an explicit clock and active-low reset
`define SSHG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define SSHG_CHECK(lbl, prop, msg) \
    `SSHG_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

FILE: rtl/sshg_pkg.sv
// ----------------------------------------------------------------------------
// sshg_pkg
// shared constants and types of the sorting cell chain
// ----------------------------------------------------------------------------
package sshg_pkg;

    localparam int MAX_ELEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
    localparam int RND_W     = $clog2(MAX_ELEMS);

    typedef logic signed [DATA_W-1:0] t_data;

    typedef struct packed {
        logic load;
        logic unload;
        logic sort;
        logic odd_round;
        logic desc;
    } t_cell_ctl;

endpackage

FILE: rtl/sshg_in_if.sv
// ----------------------------------------------------------------------------
// sshg_in_if
// element request channel
// ----------------------------------------------------------------------------
interface sshg_in_if
    import sshg_pkg::*;
;
    logic  valid;
    logic  ready;
    t_data value;
    logic  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

FILE: rtl/sshg_out_if.sv
// ----------------------------------------------------------------------------
// sshg_out_if
// sorted result request channel
// ----------------------------------------------------------------------------
interface sshg_out_if
    import sshg_pkg::*;
;
    logic  valid;
    logic  ready;
    t_data sorted_value;
    logic  final_res;
    logic  overflow;

    modport source (output valid, output sorted_value, output final_res,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input final_res,
                    input overflow, output ready);
endinterface

FILE: rtl/sshg_cell.sv
// ----------------------------------------------------------------------------
// sshg_cell
// one slot of the chain: shifts right on load, left on unload, and does
// odd-even compare-exchange with a neighbor during sorting
// ----------------------------------------------------------------------------
module sshg_cell
    import sshg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_pos_odd,
    input  t_data     i_left_val,
    input  logic      i_left_vld,
    input  t_data     i_right_val,
    input  logic      i_right_vld,
    output t_data     o_val,
    output logic      o_vld
);

    t_data r_val;
    t_data n_val;
    logic  r_vld;
    logic  n_vld;

    logic  w_right;
    t_data w_p_val;
    logic  w_p_vld;
    logic  w_p_first;
    logic  w_own_first;

    assign w_right = (i_pos_odd == i_ctl.odd_round);
    assign w_p_val = w_right ? i_right_val : i_left_val;
    assign w_p_vld = w_right ? i_right_vld : i_left_vld;

    assign w_p_first   = i_ctl.desc ? (w_p_val > r_val) : (w_p_val < r_val);
    assign w_own_first = i_ctl.desc ? (r_val > w_p_val) : (r_val < w_p_val);

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.load) begin
            n_val = i_left_val;
            n_vld = i_left_vld;
        end else if (i_ctl.unload) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctl.sort && r_vld && w_p_vld) begin
            if (w_right ? w_p_first : w_own_first) begin
                n_val = w_p_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_val = r_val;
    assign o_vld = r_vld;

endmodule

FILE: rtl/shell_sort_halving_gaps.sv
// load: one element per cycle; elements beyond 64 are dropped and flagged
// sort: rounds of odd-even exchange in the cell chain after the last element
// emit: one result per cycle while the receiver is ready
// synchronous active-low reset empties the chain and clears the order bit
// ----------------------------------------------------------------------------
// shell_sort_halving_gaps
// collects a set of signed values, sorts it in a chain of cells and emits it
// ----------------------------------------------------------------------------
module shell_sort_halving_gaps
    import sshg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    sshg_in_if.sink           i_in,
    sshg_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [RND_W-1:0] r_round;
    logic [RND_W-1:0] n_round;
    logic             r_dropped;
    logic             n_dropped;
    logic             r_desc;
    logic             r_dir;
    logic             n_dir;

    logic      w_in_acc;
    logic      w_out_acc;
    logic      w_room;
    t_cell_ctl w_ctl;

    t_data w_val [MAX_ELEMS];
    logic  w_vld [MAX_ELEMS];

    assign w_room    = (r_count < CNT_W'(MAX_ELEMS));
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_ctl.load      = w_in_acc && w_room;
    assign w_ctl.unload    = w_out_acc;
    assign w_ctl.sort      = (r_state == ST_SORT);
    assign w_ctl.odd_round = r_round[0];
    assign w_ctl.desc      = r_dir;

    // cell chain
    for (genvar g = 0; g < MAX_ELEMS; g++) begin : g_cell
        t_data w_lv;
        logic  w_lvld;
        t_data w_rv;
        logic  w_rvld;

        if (g == 0) begin : g_head
            assign w_lv   = i_in.value;
            assign w_lvld = w_ctl.load;
        end else begin : g_mid
            assign w_lv   = w_val[g-1];
            assign w_lvld = w_vld[g-1];
        end

        if (g == MAX_ELEMS - 1) begin : g_tail
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_body
            assign w_rv   = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end

        sshg_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pos_odd   (1'(g % 2)),
            .i_left_val  (w_lv),
            .i_left_vld  (w_lvld),
            .i_right_val (w_rv),
            .i_right_vld (w_rvld),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_round   = r_round;
        n_dropped = r_dropped;
        n_dir     = r_dir;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = ST_SORT;
                        n_round = '0;
                        n_dir   = r_desc;
                    end
                end
            end
            ST_SORT: begin
                n_round = r_round + RND_W'(1);
                if (r_round == RND_W'(MAX_ELEMS - 1)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state   = ST_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_round   <= '0;
            r_dropped <= 1'b0;
            r_dir     <= 1'b0;
            r_desc    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_round   <= n_round;
            r_dropped <= n_dropped;
            r_dir     <= n_dir;
            if (i_cfg_we) begin
                r_desc <= i_cfg_wdata;
            end
        end
    end

    assign i_in.ready         = (r_state == ST_LOAD);
    assign o_out.valid        = (r_state == ST_EMIT);
    assign o_out.sorted_value = w_val[0];
    assign o_out.final_res    = (r_count == CNT_W'(1));
    assign o_out.overflow     = r_dropped;

endmodule

FILE: rtl/sshg_checker.sv
// ----------------------------------------------------------------------------
// sshg_checker
// port-level checks of the sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "shell_sort_halving_gaps_macros.svh"

module sshg_checker
    import sshg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_ready,
    input  logic  i_in_last,
    input  logic  i_out_valid,
    input  logic  i_out_ready,
    input  t_data i_out_value,
    input  logic  i_out_final
);

    // loading and emitting never overlap
    `SSHG_CHECK(a_no_overlap, !(i_in_ready && i_out_valid), "load and emit overlap")

    // a stalled result holds
    `SSHG_CHECK(a_out_hold,
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_final)),
        "stalled result changed")

    // after the final result the block is loading again
    `SSHG_CHECK(a_final_ends,
        (i_out_valid && i_out_ready && i_out_final) |=> (!i_out_valid && i_in_ready),
        "set not closed after final result")

    // the last element starts a sort pass with both sides held off
    `SSHG_CHECK(a_last_sorts,
        (i_in_valid && i_in_ready && i_in_last) |=> (!i_in_ready && !i_out_valid),
        "no sort pass after last element")

endmodule

bind shell_sort_halving_gaps sshg_checker u_sshg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.sorted_value),
    .i_out_final (o_out.final_res)
);

FILE: bench/shell_sort_halving_gaps_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_sort_halving_gaps_tb
// loads sets of signed values, checks every sorted result against a local
// shell sort with halving gaps, in both orders, with sets that fill and
// overflow the store, under several patterns of sender and receiver stalls
// ----------------------------------------------------------------------------
module shell_sort_halving_gaps_tb;
    import sshg_pkg::*;

    localparam int     DIRECTED_ROWS = 12;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     SMALL_BUDGET  = 14;
    localparam t_data  VAL_MAX       = 32'sh7fff_ffff;
    localparam t_data  VAL_MIN       = 32'sh8000_0000;
    localparam logic   ORDER_ASC     = 1'b0;
    localparam logic   ORDER_DESC    = 1'b1;

    typedef struct packed {
        t_data value;
        logic  final_res;
        logic  overflow;
    } t_sorted_result;

    typedef struct packed {
        t_data value;
        logic  last;
        logic  typed;
        t_data exp_value;
        logic  exp_overflow;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sshg_in_if  in_ch ();
    sshg_out_if out_ch ();

    shell_sort_halving_gaps uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // local copy of the set being loaded and of the order bit
    t_data          held_set [MAX_ELEMS];
    int             held_count;
    logic           lost_flag;
    logic           order_desc;
    t_sorted_result pending_sorted [$];
    int             mismatches;
    int             send_idle_pct;
    int             recv_stall_pct;

    t_directed_row directed_table [DIRECTED_ROWS] = '{
        '{VAL_MAX,    1'b1, 1'b1, VAL_MAX, 1'b0},
        '{VAL_MIN,    1'b1, 1'b1, VAL_MIN, 1'b0},
        '{32'sd0,     1'b1, 1'b1, 32'sd0,  1'b0},
        '{32'sd5,     1'b0, 1'b0, 32'sd0,  1'b0},
        '{-32'sd3,    1'b0, 1'b0, 32'sd0,  1'b0},
        '{32'sd5,     1'b0, 1'b0, 32'sd0,  1'b0},
        '{VAL_MIN,    1'b0, 1'b0, 32'sd0,  1'b0},
        '{VAL_MAX,    1'b0, 1'b0, 32'sd0,  1'b0},
        '{-32'sd1,    1'b0, 1'b0, 32'sd0,  1'b0},
        '{32'sd1,     1'b1, 1'b0, 32'sd0,  1'b0},
        '{32'sd7,     1'b0, 1'b0, 32'sd0,  1'b0},
        '{32'sd7,     1'b1, 1'b0, 32'sd0,  1'b0}
    };

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic precedes(t_data a, t_data b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    // store one element; on the end of a set, sort it and queue its results
    task automatic take_element(t_data v, logic l);
        t_data work [MAX_ELEMS];
        t_data held;
        int    n;
        int    gap;
        int    i;
        int    j;
        if (held_count < MAX_ELEMS) begin
            held_set[held_count] = v;
            held_count++;
        end else begin
            lost_flag = 1'b1;
        end
        if (l) begin
            n = held_count;
            for (i = 0; i < n; i++) work[i] = held_set[i];
            for (gap = n / 2; gap > 0; gap = gap / 2) begin
                for (i = gap; i < n; i++) begin
                    held = work[i];
                    j = i;
                    while (j >= gap && precedes(held, work[j - gap])) begin
                        work[j] = work[j - gap];
                        j -= gap;
                    end
                    work[j] = held;
                end
            end
            for (i = 0; i < n; i++) begin
                pending_sorted.push_back('{work[i], logic'(i == n - 1), lost_flag});
            end
            held_count = 0;
            lost_flag = 1'b0;
        end
    endtask

    task automatic send_item(t_data v, logic l);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.value = v;
        in_ch.last  = l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        take_element(v, l);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_order(logic desc);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = desc;
        @(posedge i_clk);
        order_desc = desc;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        while (pending_sorted.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_sorted.size() != 0) begin
            $display("%0t: %0d sorted results never arrived", $time, pending_sorted.size());
            mismatches++;
            pending_sorted.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_data rand_value();
        t_data v;
        case ($urandom_range(0, 9))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2, 3: begin
                v = $urandom_range(0, 15);
                v = v - 8;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_set(int size);
        int k;
        for (k = 0; k < size; k++) send_item(rand_value(), logic'(k == size - 1));
    endtask

    task automatic run_directed();
        int r;
        for (r = 0; r < DIRECTED_ROWS; r++) begin
            send_item(directed_table[r].value, directed_table[r].last);
            if (directed_table[r].typed) begin
                void'(pending_sorted.pop_back());
                pending_sorted.push_back('{directed_table[r].exp_value, 1'b1,
                                           directed_table[r].exp_overflow});
            end
        end
        release_input();
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        t_sorted_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result value=%0d final=%b overflow=%b",
                         $time, out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
                mismatches++;
            end else begin
                want = pending_sorted.pop_front();
                if (want.value !== out_ch.sorted_value || want.final_res !== out_ch.final_res
                        || want.overflow !== out_ch.overflow) begin
                    $display({"%0t: expected value=%0d final=%b overflow=%b, ",
                              "got value=%0d final=%b overflow=%b"},
                             $time, want.value, want.final_res, want.overflow,
                             out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int p;
        int sent;
        int size;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.value    = '0;
        in_ch.last     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        held_count     = 0;
        lost_flag      = 1'b0;
        order_desc     = ORDER_ASC;
        mismatches     = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_order(ORDER_ASC);
        run_directed();
        drain_results();
        write_order(ORDER_DESC);
        run_directed();
        drain_results();

        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            write_order((p % 2 == 0) ? ORDER_ASC : ORDER_DESC);
            // an overflowing set in the last phase
            if (p == 3) send_set(MAX_ELEMS + $urandom_range(1, 4));
            sent = 0;
            while (sent < SMALL_BUDGET) begin
                size = $urandom_range(1, 12);
                send_set(size);
                sent += size;
            end
            release_input();
            drain_results();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: shell_sort_halving_gaps.f
+incdir+rtl
rtl/sshg_pkg.sv
rtl/sshg_in_if.sv
rtl/sshg_out_if.sv
rtl/sshg_cell.sv
rtl/shell_sort_halving_gaps.sv
rtl/sshg_checker.sv
bench/shell_sort_halving_gaps_tb.sv
